FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/jfpf_pkg.sv
// ---------------------------------------------------------------------------
// jfpf_pkg
// Types, constants, microprogram and tanh table of the friction feedforward.
// ---------------------------------------------------------------------------
package jfpf_pkg;

  localparam int MAX_JOINTS_DEF = 8;
  localparam int DATA_W         = 16;
  localparam int JOINT_W        = 4;
  localparam int KIND_W         = 2;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int LIM_W          = 15;
  localparam int PC_W           = 4;

  localparam logic [12:0] TENTH_Q16 = 13'd6554;

  localparam logic             RST_FRICTION_ENABLE   = 1'b1;
  localparam logic             RST_POSTURE_ENABLE    = 1'b0;
  localparam logic [15:0]      RST_FRICTION_SCALE    = 16'd11469;
  localparam logic [LIM_W-1:0] RST_FRICTION_LIMIT    = 15'd768;
  localparam logic [LIM_W-1:0] RST_VELOCITY_DEADBAND = 15'd0;
  localparam logic [LIM_W-1:0] RST_POSTURE_LIMIT     = 15'd512;
  localparam logic [3:0]       RST_JOINT_COUNT       = 4'd7;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD    = 2'd0,
    KIND_SAMPLE  = 2'd1,
    KIND_GRAVITY = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRICTION_ENABLE   = 3'd0,
    REG_POSTURE_ENABLE    = 3'd1,
    REG_FRICTION_SCALE    = 3'd2,
    REG_FRICTION_LIMIT    = 3'd3,
    REG_VELOCITY_DEADBAND = 3'd4,
    REG_POSTURE_LIMIT     = 3'd5,
    REG_JOINT_COUNT       = 3'd6
  } reg_idx_t;

  typedef enum logic [3:0] {
    UOP_KW,
    UOP_ARG_SCALE,
    UOP_ARG_SAT,
    UOP_INTERP,
    UOP_TANH_FC,
    UOP_FRIC_MAG,
    UOP_FRIC_ADD,
    UOP_SPRING,
    UOP_DAMP,
    UOP_POST_DIFF,
    UOP_POST_ADD,
    UOP_DONE
  } uop_t;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_SKIP_FRIC,
    COND_SKIP_POST
  } cond_t;

  typedef struct packed {
    uop_t            op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  localparam logic [PC_W-1:0] PC_KW        = 4'd0;
  localparam logic [PC_W-1:0] PC_ARG_SCALE = 4'd1;
  localparam logic [PC_W-1:0] PC_ARG_SAT   = 4'd2;
  localparam logic [PC_W-1:0] PC_INTERP    = 4'd3;
  localparam logic [PC_W-1:0] PC_TANH_FC   = 4'd4;
  localparam logic [PC_W-1:0] PC_FRIC_MAG  = 4'd5;
  localparam logic [PC_W-1:0] PC_FRIC_ADD  = 4'd6;
  localparam logic [PC_W-1:0] PC_SPRING    = 4'd7;
  localparam logic [PC_W-1:0] PC_DAMP      = 4'd8;
  localparam logic [PC_W-1:0] PC_POST_DIFF = 4'd9;
  localparam logic [PC_W-1:0] PC_POST_ADD  = 4'd10;
  localparam logic [PC_W-1:0] PC_DONE      = 4'd11;

  function automatic ctrl_word_t prog_word(input logic [PC_W-1:0] pc);
    ctrl_word_t cw;
    cw = '{op: UOP_DONE, cond: COND_NONE, target: PC_DONE};
    unique case (pc)
      PC_KW:        cw = '{op: UOP_KW,        cond: COND_SKIP_FRIC, target: PC_SPRING};
      PC_ARG_SCALE: cw = '{op: UOP_ARG_SCALE, cond: COND_NONE,      target: PC_DONE};
      PC_ARG_SAT:   cw = '{op: UOP_ARG_SAT,   cond: COND_NONE,      target: PC_DONE};
      PC_INTERP:    cw = '{op: UOP_INTERP,    cond: COND_NONE,      target: PC_DONE};
      PC_TANH_FC:   cw = '{op: UOP_TANH_FC,   cond: COND_NONE,      target: PC_DONE};
      PC_FRIC_MAG:  cw = '{op: UOP_FRIC_MAG,  cond: COND_NONE,      target: PC_DONE};
      PC_FRIC_ADD:  cw = '{op: UOP_FRIC_ADD,  cond: COND_NONE,      target: PC_DONE};
      PC_SPRING:    cw = '{op: UOP_SPRING,    cond: COND_SKIP_POST, target: PC_DONE};
      PC_DAMP:      cw = '{op: UOP_DAMP,      cond: COND_NONE,      target: PC_DONE};
      PC_POST_DIFF: cw = '{op: UOP_POST_DIFF, cond: COND_NONE,      target: PC_DONE};
      PC_POST_ADD:  cw = '{op: UOP_POST_ADD,  cond: COND_NONE,      target: PC_DONE};
      default:      cw = '{op: UOP_DONE,      cond: COND_NONE,      target: PC_DONE};
    endcase
    return cw;
  endfunction

  // tanh at 0, 0.5, ... 4.0 in Q0.15
  function automatic logic [14:0] tanh_pt(input logic [3:0] i);
    logic [14:0] v;
    unique case (i)
      4'd0:    v = 15'd0;
      4'd1:    v = 15'd15143;
      4'd2:    v = 15'd24956;
      4'd3:    v = 15'd29660;
      4'd4:    v = 15'd31589;
      4'd5:    v = 15'd32329;
      4'd6:    v = 15'd32606;
      4'd7:    v = 15'd32708;
      default: v = 15'd32746;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] mag16(input logic signed [15:0] v);
    logic [15:0] m;
    m = v[15] ? (~v + 16'd1) : v;
    return m;
  endfunction

endpackage

FILE: rtl/jfpf_in_if.sv
// ---------------------------------------------------------------------------
// jfpf_in_if
// Input item channel: valid/ready with the item fields.
// ---------------------------------------------------------------------------
interface jfpf_in_if;
  logic                                      valid;
  logic                                      ready;
  logic        [jfpf_pkg::KIND_W-1:0]        kind;
  logic        [jfpf_pkg::JOINT_W-1:0]       joint;
  logic signed [jfpf_pkg::DATA_W-1:0]        coulomb_level;
  logic signed [jfpf_pkg::DATA_W-1:0]        sharpness;
  logic signed [jfpf_pkg::DATA_W-1:0]        spring_gain;
  logic signed [jfpf_pkg::DATA_W-1:0]        damping_gain;
  logic signed [jfpf_pkg::DATA_W-1:0]        rest_position;
  logic signed [jfpf_pkg::DATA_W-1:0]        velocity;
  logic signed [jfpf_pkg::DATA_W-1:0]        position;
  logic signed [jfpf_pkg::DATA_W-1:0]        gravity_torque;

  modport source (
    output valid, kind, joint, coulomb_level, sharpness, spring_gain, damping_gain,
           rest_position, velocity, position, gravity_torque,
    input  ready
  );
  modport sink (
    input  valid, kind, joint, coulomb_level, sharpness, spring_gain, damping_gain,
           rest_position, velocity, position, gravity_torque,
    output ready
  );
endinterface

FILE: rtl/jfpf_out_if.sv
// ---------------------------------------------------------------------------
// jfpf_out_if
// Result channel: valid/ready with joint index and torque command.
// ---------------------------------------------------------------------------
interface jfpf_out_if;
  logic                                valid;
  logic                                ready;
  logic        [jfpf_pkg::JOINT_W-1:0] joint_out;
  logic signed [jfpf_pkg::DATA_W-1:0]  torque_command;

  modport source (output valid, joint_out, torque_command, input ready);
  modport sink (input valid, joint_out, torque_command, output ready);
endinterface

FILE: rtl/joint_friction_posture_feedforward_unit.sv
// ---------------------------------------------------------------------------
// joint_friction_posture_feedforward_unit
// Load and sample beats update the joint tables when taken. A gravity beat
// runs a 12-step microprogram on one shared 33x18 multiplier, skipping the
// friction or posture steps when they do not apply. Input waits until the
// result is in the output register, where it waits while input is taken.
// Synchronous active-high reset restores register defaults and zeroes tables.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module joint_friction_posture_feedforward_unit #(
  parameter int MAX_JOINTS = jfpf_pkg::MAX_JOINTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [jfpf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [jfpf_pkg::CFG_DATA_W-1:0]  cfg_data,
  jfpf_in_if.sink                          items,
  jfpf_out_if.source                       results
);
  import jfpf_pkg::*;

  localparam int IDX_W = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

  // configuration
  logic             fric_en;
  logic             post_en;
  logic [15:0]      fric_scale;
  logic [LIM_W-1:0] fric_limit;
  logic [LIM_W-1:0] vel_deadband;
  logic [LIM_W-1:0] post_limit;
  logic [3:0]       joint_count;

  // joint tables
  logic signed [15:0] coulomb_tbl  [MAX_JOINTS];
  logic signed [15:0] sharp_tbl    [MAX_JOINTS];
  logic signed [15:0] spring_tbl   [MAX_JOINTS];
  logic signed [15:0] damp_tbl     [MAX_JOINTS];
  logic signed [15:0] rest_tbl     [MAX_JOINTS];
  logic signed [15:0] vel_tbl      [MAX_JOINTS];
  logic signed [15:0] pos_tbl      [MAX_JOINTS];

  // sequencer and datapath
  logic               busy;
  logic [PC_W-1:0]    pc;
  logic [PC_W-1:0]    pc_next;
  ctrl_word_t         ctrl;
  logic               take_jump;
  logic [15:0]        ak;
  logic [15:0]        aw;
  logic [15:0]        afc;
  logic               neg;
  logic signed [15:0] kp;
  logic signed [15:0] kd;
  logic signed [15:0] w;
  logic signed [16:0] err;
  logic               fr_on;
  logic               po_on;
  logic [3:0]         joint_q;
  logic signed [17:0] tau;
  logic signed [50:0] p;
  logic [14:0]        t;
  logic [10:0]        arg;
  logic signed [34:0] x;

  // output register
  logic               out_valid;
  logic [3:0]         out_joint;
  logic signed [15:0] out_torque;

  // accept side
  logic               in_fire;
  logic               stored;
  logic               comp;
  logic [IDX_W-1:0]   idx;
  logic signed [15:0] rd_w;
  logic signed [15:0] rd_fc;
  logic signed [15:0] rd_k;
  logic signed [15:0] rd_kp;
  logic [15:0]        rd_aw;

  assign items.ready = !busy;
  assign in_fire     = items.valid && !busy;
  assign stored      = int'(items.joint) < MAX_JOINTS;
  assign comp        = stored && (items.joint < joint_count);
  assign idx         = items.joint[IDX_W-1:0];
  assign rd_w        = vel_tbl[idx];
  assign rd_fc       = coulomb_tbl[idx];
  assign rd_k        = sharp_tbl[idx];
  assign rd_kp       = spring_tbl[idx];
  assign rd_aw       = mag16(rd_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      fric_en      <= RST_FRICTION_ENABLE;
      post_en      <= RST_POSTURE_ENABLE;
      fric_scale   <= RST_FRICTION_SCALE;
      fric_limit   <= RST_FRICTION_LIMIT;
      vel_deadband <= RST_VELOCITY_DEADBAND;
      post_limit   <= RST_POSTURE_LIMIT;
      joint_count  <= RST_JOINT_COUNT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRICTION_ENABLE:   fric_en      <= cfg_data[0];
        REG_POSTURE_ENABLE:    post_en      <= cfg_data[0];
        REG_FRICTION_SCALE:    fric_scale   <= cfg_data;
        REG_FRICTION_LIMIT:    fric_limit   <= cfg_data[LIM_W-1:0];
        REG_VELOCITY_DEADBAND: vel_deadband <= cfg_data[LIM_W-1:0];
        REG_POSTURE_LIMIT:     post_limit   <= cfg_data[LIM_W-1:0];
        REG_JOINT_COUNT:       joint_count  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_JOINTS; i++) begin
        coulomb_tbl[i] <= '0;
        sharp_tbl[i]   <= '0;
        spring_tbl[i]  <= '0;
        damp_tbl[i]    <= '0;
        rest_tbl[i]    <= '0;
        vel_tbl[i]     <= '0;
        pos_tbl[i]     <= '0;
      end
    end else if (in_fire && stored) begin
      if (items.kind == KIND_LOAD) begin
        coulomb_tbl[idx] <= items.coulomb_level;
        sharp_tbl[idx]   <= items.sharpness;
        spring_tbl[idx]  <= items.spring_gain;
        damp_tbl[idx]    <= items.damping_gain;
        rest_tbl[idx]    <= items.rest_position;
      end else if (items.kind == KIND_SAMPLE) begin
        vel_tbl[idx] <= items.velocity;
        pos_tbl[idx] <= items.position;
      end
    end
  end

  // sequencer
  assign ctrl      = prog_word(pc);
  assign take_jump = ((ctrl.cond == COND_SKIP_FRIC) && !fr_on) ||
                     ((ctrl.cond == COND_SKIP_POST) && !po_on);

  logic out_free;
  assign out_free = !out_valid || results.ready;

  always_comb begin
    pc_next = pc;
    if (!busy) begin
      pc_next = PC_KW;
    end else if (ctrl.op == UOP_DONE) begin
      pc_next = pc;
    end else if (take_jump) begin
      pc_next = ctrl.target;
    end else begin
      pc_next = pc + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= PC_KW;
    end else begin
      pc <= pc_next;
      if (in_fire && (items.kind == KIND_GRAVITY)) begin
        busy <= 1'b1;
      end else if (busy && (ctrl.op == UOP_DONE) && out_free) begin
        busy <= 1'b0;
      end
    end
  end

  // shared multiplier
  logic signed [32:0] ma;
  logic signed [17:0] mb;
  logic signed [50:0] prod;
  logic [3:0]         seg;
  logic               tsat;
  logic [14:0]        lo;
  logic [14:0]        slope;

  assign seg   = arg[10:7];
  assign tsat  = arg[10];
  assign lo    = tsat ? tanh_pt(4'd8) : tanh_pt(seg);
  assign slope = tsat ? 15'd0 : (tanh_pt(seg + 4'd1) - tanh_pt(seg));

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (ctrl.op)
      UOP_KW: begin
        ma = {17'd0, ak};
        mb = {2'd0, aw};
      end
      UOP_ARG_SCALE: begin
        ma = {2'd0, p[30:0]};
        mb = {5'd0, TENTH_Q16};
      end
      UOP_INTERP: begin
        ma = {26'd0, arg[6:0]};
        mb = {3'd0, slope};
      end
      UOP_TANH_FC: begin
        ma = {17'd0, fric_scale};
        mb = {2'd0, afc};
      end
      UOP_FRIC_MAG: begin
        ma = {1'b0, p[31:0]};
        mb = {3'd0, t};
      end
      UOP_SPRING: begin
        ma = {{16{err[16]}}, err};
        mb = {{2{kp[15]}}, kp};
      end
      UOP_DAMP: begin
        ma = {{17{w[15]}}, w};
        mb = {{2{kd[15]}}, kd};
      end
      default: ;
    endcase
  end

  assign prod = 51'(ma) * 51'(mb);

  // friction and posture arithmetic
  logic [44:0]        arg_sum;
  logic [20:0]        arg_full;
  logic [20:0]        interp_sum;
  logic [46:0]        fric_sum;
  logic [17:0]        fric_m;
  logic [14:0]        fric_c;
  logic [34:0]        x_mag;
  logic [34:0]        post_sum;
  logic [26:0]        post_m;
  logic [14:0]        post_c;

  assign arg_sum    = {1'b0, p[43:0]} + 45'(1 << 23);
  assign arg_full   = arg_sum[44:24];
  assign interp_sum = p[20:0] + 21'd64;
  assign fric_sum   = p[46:0] + 47'(1 << 28);
  assign fric_m     = fric_sum[46:29];
  assign fric_c     = (fric_m > {3'd0, fric_limit}) ? fric_limit : fric_m[14:0];
  assign x_mag      = x[34] ? (~x + 35'd1) : x;
  assign post_sum   = x_mag + 35'd128;
  assign post_m     = post_sum[34:8];
  assign post_c     = (post_m > {12'd0, post_limit}) ? post_limit : post_m[14:0];

  always_ff @(posedge clk) begin
    if (in_fire && (items.kind == KIND_GRAVITY)) begin
      ak      <= mag16(rd_k);
      aw      <= rd_aw;
      afc     <= mag16(rd_fc);
      neg     <= rd_fc[15] ^ rd_k[15] ^ rd_w[15];
      kp      <= rd_kp;
      kd      <= damp_tbl[idx];
      w       <= rd_w;
      err     <= 17'(rest_tbl[idx]) - 17'(pos_tbl[idx]);
      fr_on   <= comp && fric_en && (rd_aw >= {1'b0, vel_deadband});
      po_on   <= comp && post_en && (rd_kp != 16'sd0);
      joint_q <= items.joint;
      tau     <= 18'(items.gravity_torque);
    end else if (busy) begin
      unique case (ctrl.op)
        UOP_KW, UOP_ARG_SCALE, UOP_INTERP, UOP_FRIC_MAG, UOP_SPRING: begin
          p <= prod;
          if (ctrl.op == UOP_INTERP) begin
            t <= lo;
          end
        end
        UOP_ARG_SAT: begin
          arg <= (|arg_full[20:10]) ? 11'd1024 : {1'b0, arg_full[9:0]};
        end
        UOP_TANH_FC: begin
          t <= t + {1'b0, interp_sum[20:7]};
          p <= prod;
        end
        UOP_FRIC_ADD: begin
          tau <= neg ? (tau - 18'(fric_c)) : (tau + 18'(fric_c));
        end
        UOP_DAMP: begin
          x <= p[34:0];
          p <= prod;
        end
        UOP_POST_DIFF: begin
          x <= x - p[34:0];
        end
        UOP_POST_ADD: begin
          tau <= x[34] ? (tau - 18'(post_c)) : (tau + 18'(post_c));
        end
        default: ;
      endcase
    end
  end

  // result register
  logic signed [15:0] tau_sat;
  assign tau_sat = (tau > 18'sd32767)  ? 16'sh7FFF :
                   (tau < -18'sd32768) ? 16'sh8000 : tau[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (busy && (ctrl.op == UOP_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy && (ctrl.op == UOP_DONE) && out_free) begin
      out_joint  <= joint_q;
      out_torque <= tau_sat;
    end
  end

  assign results.valid          = out_valid;
  assign results.joint_out      = out_joint;
  assign results.torque_command = out_torque;

  `ASSERT_NXT(a_gravity_starts, clk, rst, in_fire && (items.kind == KIND_GRAVITY), busy && (pc == PC_KW), "gravity beat did not start the program")
  `ASSERT_NXT(a_done_emits, clk, rst, busy && (ctrl.op == UOP_DONE) && out_free, results.valid && !busy, "finished program did not post a result")
  `ASSERT_IMP(a_pc_range, clk, rst, busy, pc <= PC_DONE, "step counter ran past the program")

endmodule

FILE: dv/jfpf_torque_checker.sv
// ---------------------------------------------------------------------------
// jfpf_torque_checker
// Watches the register port and both channels of the friction feedforward
// unit, keeps its own copy of the joint tables and registers, predicts the
// torque command of every gravity beat and compares it with the result beats
// in order.
// ---------------------------------------------------------------------------
module jfpf_torque_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [jfpf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jfpf_pkg::CFG_DATA_W-1:0] cfg_data,
  jfpf_in_if                              items,
  jfpf_out_if                             results,
  output int                              mismatches,
  output int                              pending,
  output int                              checked
);
  import jfpf_pkg::*;

  localparam int JOINTS = MAX_JOINTS_DEF;

  typedef struct packed {
    logic [JOINT_W-1:0] jt;
    logic [DATA_W-1:0]  tq;
  } torque_due_t;

  logic signed [15:0] coulomb_tab [JOINTS];
  logic signed [15:0] sharp_tab   [JOINTS];
  logic signed [15:0] spring_tab  [JOINTS];
  logic signed [15:0] damp_tab    [JOINTS];
  logic signed [15:0] rest_tab    [JOINTS];
  logic signed [15:0] vel_now     [JOINTS];
  logic signed [15:0] pos_now     [JOINTS];

  logic        fric_on;
  logic        post_on;
  logic [15:0] fric_scale;
  logic [14:0] fric_cap;
  logic [14:0] vel_floor;
  logic [14:0] post_cap;
  logic [3:0]  active_joints;

  torque_due_t torque_due [$];
  int          bad_count;
  int          seen_count;

  function automatic longint tanh_knot(input longint i);
    longint v;
    case (i)
      0:       v = 0;
      1:       v = 15143;
      2:       v = 24956;
      3:       v = 29660;
      4:       v = 31589;
      5:       v = 32329;
      6:       v = 32606;
      7:       v = 32708;
      default: v = 32746;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] compensated_torque(input logic [3:0] jt,
                                                     input logic signed [15:0] grav);
    longint tau, w, aw, fc, k, ak, afc, arg, seg, frac, th, m, err, p;
    bit     neg;
    tau = grav;
    if (jt < JOINTS && jt < active_joints) begin
      w  = vel_now[jt];
      aw = (w < 0) ? -w : w;
      if (fric_on && aw >= vel_floor) begin
        fc  = coulomb_tab[jt];
        k   = sharp_tab[jt];
        ak  = (k < 0) ? -k : k;
        afc = (fc < 0) ? -fc : fc;
        neg = (fc < 0) ^ (k < 0) ^ (w < 0);
        arg = (ak * aw * 6554 + (longint'(1) << 23)) >> 24;
        seg = arg >> 7;
        if (seg >= 8) begin
          th = tanh_knot(8);
        end else begin
          frac = arg & 127;
          th = tanh_knot(seg) +
               (((tanh_knot(seg + 1) - tanh_knot(seg)) * frac + 64) >> 7);
        end
        m = (longint'(fric_scale) * afc * th + (longint'(1) << 28)) >> 29;
        if (m > fric_cap) m = fric_cap;
        tau = neg ? tau - m : tau + m;
      end
      if (post_on && spring_tab[jt] != 0) begin
        err = longint'(rest_tab[jt]) - longint'(pos_now[jt]);
        p   = longint'(spring_tab[jt]) * err - longint'(damp_tab[jt]) * w;
        m   = (((p < 0) ? -p : p) + 128) >> 8;
        if (m > post_cap) m = post_cap;
        tau = (p < 0) ? tau - m : tau + m;
      end
    end
    if (tau > 32767) tau = 32767;
    if (tau < -32768) tau = -32768;
    return tau[15:0];
  endfunction

  always @(posedge clk) begin
    torque_due_t due;
    if (rst) begin
      fric_on       = RST_FRICTION_ENABLE;
      post_on       = RST_POSTURE_ENABLE;
      fric_scale    = RST_FRICTION_SCALE;
      fric_cap      = RST_FRICTION_LIMIT;
      vel_floor     = RST_VELOCITY_DEADBAND;
      post_cap      = RST_POSTURE_LIMIT;
      active_joints = RST_JOINT_COUNT;
      for (int i = 0; i < JOINTS; i++) begin
        coulomb_tab[i] = '0;
        sharp_tab[i]   = '0;
        spring_tab[i]  = '0;
        damp_tab[i]    = '0;
        rest_tab[i]    = '0;
        vel_now[i]     = '0;
        pos_now[i]     = '0;
      end
      torque_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FRICTION_ENABLE:   fric_on       = cfg_data[0];
          REG_POSTURE_ENABLE:    post_on       = cfg_data[0];
          REG_FRICTION_SCALE:    fric_scale    = cfg_data;
          REG_FRICTION_LIMIT:    fric_cap      = cfg_data[14:0];
          REG_VELOCITY_DEADBAND: vel_floor     = cfg_data[14:0];
          REG_POSTURE_LIMIT:     post_cap      = cfg_data[14:0];
          REG_JOINT_COUNT:       active_joints = cfg_data[3:0];
          default: ;
        endcase
      end
      if (results.valid && results.ready) begin
        seen_count++;
        if (torque_due.size() == 0) begin
          bad_count++;
          $display("%0t: unexpected result beat joint %0d torque %0d", $time,
                   results.joint_out, results.torque_command);
        end else begin
          due = torque_due.pop_front();
          if (results.joint_out !== due.jt) begin
            bad_count++;
            $display("%0t: joint_out expected %0d actual %0d", $time, due.jt,
                     results.joint_out);
          end
          if (results.torque_command !== due.tq) begin
            bad_count++;
            $display("%0t: torque_command joint %0d expected %0d actual %0d", $time,
                     due.jt, $signed(due.tq), results.torque_command);
          end
        end
      end
      if (items.valid && items.ready) begin
        case (items.kind)
          KIND_LOAD: begin
            if (items.joint < JOINTS) begin
              coulomb_tab[items.joint] = items.coulomb_level;
              sharp_tab[items.joint]   = items.sharpness;
              spring_tab[items.joint]  = items.spring_gain;
              damp_tab[items.joint]    = items.damping_gain;
              rest_tab[items.joint]    = items.rest_position;
            end
          end
          KIND_SAMPLE: begin
            if (items.joint < JOINTS) begin
              vel_now[items.joint] = items.velocity;
              pos_now[items.joint] = items.position;
            end
          end
          KIND_GRAVITY: begin
            due.jt = items.joint;
            due.tq = compensated_torque(items.joint, items.gravity_torque);
            torque_due = {torque_due, due};
          end
          default: ;
        endcase
      end
    end
    mismatches <= bad_count;
    pending    <= torque_due.size();
    checked    <= seen_count;
  end

endmodule

FILE: dv/joint_friction_posture_feedforward_unit_tb.sv
// ---------------------------------------------------------------------------
// joint_friction_posture_feedforward_unit_tb
// Drives coefficient loads, joint samples and gravity beats into the unit
// through a directed opener and randomized load/sample/gravity sequences
// under several register settings and handshake patterns, including a long
// result back-pressure stretch. The checker beside the unit predicts and
// compares every torque command.
// ---------------------------------------------------------------------------
module joint_friction_posture_feedforward_unit_tb;
  import jfpf_pkg::*;

  localparam int             SETTLE_CYCLES = 20;
  localparam int             HOLD_CYCLES   = 300;
  localparam int             PHASE_ITEMS   = 90;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    kind_t              kind;
    logic [JOINT_W-1:0] joint;
    logic [15:0]        fc;
    logic [15:0]        k;
    logic [15:0]        kp;
    logic [15:0]        kd;
    logic [15:0]        rest;
    logic [15:0]        w;
    logic [15:0]        q;
    logic [15:0]        grav;
  } joint_item_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatches;
  int pending;
  int checked;
  int items_sent;
  int gap_pct;
  int stall_pct;
  int hold_asks;
  int hold_done;
  int hold_left;

  jfpf_in_if  items_ch ();
  jfpf_out_if results_ch ();

  joint_friction_posture_feedforward_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (items_ch),
    .results   (results_ch)
  );

  jfpf_torque_checker torque_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .items      (items_ch),
    .results    (results_ch),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result back-pressure: random stalls, or a long counted hold on request
  initial begin
    results_ch.ready = 1'b0;
    hold_done = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        results_ch.ready <= 1'b0;
        hold_left--;
        if (hold_left == 0) hold_done++;
      end else if (hold_asks != hold_done) begin
        results_ch.ready <= 1'b0;
        hold_left = HOLD_CYCLES;
      end else begin
        results_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic logic [15:0] rand_q16();
    logic [15:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = 16'($urandom);
      4, 5, 6:    v = 16'($urandom_range(1023)) - 16'd512;
      7:          v = 16'h7fff;
      8:          v = 16'h8000;
      default:    v = 16'h0000;
    endcase
    return v;
  endfunction

  function automatic joint_item_t rand_item(input kind_t kd, input logic [3:0] jt);
    joint_item_t it;
    it.kind  = kd;
    it.joint = jt;
    it.fc    = rand_q16();
    it.k     = rand_q16();
    it.kp    = rand_q16();
    it.kd    = rand_q16();
    it.rest  = rand_q16();
    it.w     = rand_q16();
    it.q     = rand_q16();
    it.grav  = rand_q16();
    return it;
  endfunction

  function automatic joint_item_t item_of(input kind_t kd, input logic [3:0] jt,
                                          input logic [15:0] fc, k, kp, kd_gain,
                                          input logic [15:0] rest, w, q, grav);
    joint_item_t it;
    it = '{kind: kd, joint: jt, fc: fc, k: k, kp: kp, kd: kd_gain, rest: rest,
           w: w, q: q, grav: grav};
    return it;
  endfunction

  task automatic offer(input joint_item_t it);
    while ($urandom_range(99) < gap_pct) begin
      items_ch.valid <= 1'b0;
      @(posedge clk);
    end
    items_ch.valid          <= 1'b1;
    items_ch.kind           <= it.kind;
    items_ch.joint          <= it.joint;
    items_ch.coulomb_level  <= it.fc;
    items_ch.sharpness      <= it.k;
    items_ch.spring_gain    <= it.kp;
    items_ch.damping_gain   <= it.kd;
    items_ch.rest_position  <= it.rest;
    items_ch.velocity       <= it.w;
    items_ch.position       <= it.q;
    items_ch.gravity_torque <= it.grav;
    do @(posedge clk); while (!items_ch.ready);
    if (it.kind != KIND_NONE && (it.joint < MAX_JOINTS_DEF || it.kind == KIND_GRAVITY))
      items_sent++;
  endtask

  task automatic settle();
    items_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [15:0] fe, pe, scale, flim, dead, plim, jc,
                               input int mode);
    write_reg(REG_FRICTION_ENABLE, fe);
    write_reg(REG_POSTURE_ENABLE, pe);
    write_reg(REG_FRICTION_SCALE, scale);
    write_reg(REG_FRICTION_LIMIT, flim);
    write_reg(REG_VELOCITY_DEADBAND, dead);
    write_reg(REG_POSTURE_LIMIT, plim);
    write_reg(REG_JOINT_COUNT, jc);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (mode)
      0:       begin gap_pct = 0;  stall_pct = 0;  end
      1:       begin gap_pct = 67; stall_pct = 0;  end
      2:       begin gap_pct = 0;  stall_pct = 67; end
      default: begin gap_pct = 34; stall_pct = 34; end
    endcase
  endtask

  // mostly load/sample/gravity sequences on one joint, some loose beats
  task automatic traffic(input int target, input bit squeeze);
    int          start;
    int          n;
    bit          paused;
    logic [3:0]  jt;
    start  = items_sent;
    paused = 1'b0;
    if (squeeze) hold_asks++;
    while (items_sent - start < target) begin
      if (!paused && items_sent - start >= target / 2) begin
        paused = 1'b1;
        items_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      if ($urandom_range(99) < 75) begin
        jt = ($urandom_range(99) < 90) ? 4'($urandom_range(7)) : 4'($urandom_range(15, 8));
        if ($urandom_range(1) == 1) offer(rand_item(KIND_LOAD, jt));
        offer(rand_item(KIND_SAMPLE, jt));
        n = $urandom_range(3, 1);
        repeat (n) offer(rand_item(KIND_GRAVITY, jt));
      end else begin
        offer(rand_item(kind_t'($urandom_range(3)), 4'($urandom_range(15))));
      end
    end
    settle();
  endtask

  initial begin
    rst                     = 1'b1;
    cfg_we                  = 1'b0;
    cfg_index               = '0;
    cfg_data                = '0;
    items_ch.valid          = 1'b0;
    items_ch.kind           = KIND_LOAD;
    items_ch.joint          = '0;
    items_ch.coulomb_level  = '0;
    items_ch.sharpness      = '0;
    items_ch.spring_gain    = '0;
    items_ch.damping_gain   = '0;
    items_ch.rest_position  = '0;
    items_ch.velocity       = '0;
    items_ch.position       = '0;
    items_ch.gravity_torque = '0;
    items_sent              = 0;
    gap_pct                 = 0;
    stall_pct               = 0;
    hold_asks               = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    write_reg(REG_POSTURE_ENABLE, 16'd1);
    cfg_we <= 1'b0;
    @(posedge clk);

    offer(item_of(KIND_GRAVITY, 4'd0, 0, 0, 0, 0, 0, 0, 0, 16'h7fff));
    offer(item_of(KIND_LOAD, 4'd0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000,
                  0, 0, 0));
    offer(item_of(KIND_SAMPLE, 4'd0, 0, 0, 0, 0, 0, 16'h8000, 16'h7fff, 0));
    offer(item_of(KIND_GRAVITY, 4'd0, 0, 0, 0, 0, 0, 0, 0, 16'h8000));
    offer(item_of(KIND_GRAVITY, 4'd0, 0, 0, 0, 0, 0, 0, 0, 16'h7fff));
    offer(item_of(KIND_LOAD, 4'd1, 16'h8000, 16'h8000, 0, 16'd1, 0, 0, 0, 0));
    offer(item_of(KIND_SAMPLE, 4'd1, 0, 0, 0, 0, 0, 16'h7fff, 16'h8000, 0));
    offer(item_of(KIND_GRAVITY, 4'd1, 0, 0, 0, 0, 0, 0, 0, 16'h7fff));
    offer(item_of(KIND_LOAD, 4'd2, 16'd256, 16'd256, 16'd256, 16'd256, 16'd256, 0, 0, 0));
    offer(item_of(KIND_SAMPLE, 4'd2, 0, 0, 0, 0, 0, 16'd5, 16'hff00, 0));
    offer(item_of(KIND_GRAVITY, 4'd2, 0, 0, 0, 0, 0, 0, 0, 16'd0));
    offer(item_of(KIND_SAMPLE, 4'd2, 0, 0, 0, 0, 0, 16'd0, 16'd256, 0));
    offer(item_of(KIND_GRAVITY, 4'd2, 0, 0, 0, 0, 0, 0, 0, 16'hfe00));
    offer(item_of(KIND_SAMPLE, 4'd2, 0, 0, 0, 0, 0, 16'd1500, 16'd0, 0));
    offer(item_of(KIND_GRAVITY, 4'd2, 0, 0, 0, 0, 0, 0, 0, 16'd100));
    offer(item_of(KIND_LOAD, 4'd6, 16'hfc00, 16'd512, 16'hff00, 16'd128, 16'd64, 0, 0, 0));
    offer(item_of(KIND_SAMPLE, 4'd6, 0, 0, 0, 0, 0, 16'hfff0, 16'd300, 0));
    offer(item_of(KIND_GRAVITY, 4'd6, 0, 0, 0, 0, 0, 0, 0, 16'd10));
    offer(item_of(KIND_LOAD, 4'd7, 16'd512, 16'd512, 16'd512, 16'd0, 16'd0, 0, 0, 0));
    offer(item_of(KIND_SAMPLE, 4'd7, 0, 0, 0, 0, 0, 16'd256, 16'd0, 0));
    offer(item_of(KIND_GRAVITY, 4'd7, 0, 0, 0, 0, 0, 0, 0, 16'd77));
    offer(item_of(KIND_LOAD, 4'd15, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                  0, 0, 0));
    offer(item_of(KIND_SAMPLE, 4'd12, 0, 0, 0, 0, 0, 16'h7fff, 16'h7fff, 0));
    offer(item_of(KIND_GRAVITY, 4'd15, 0, 0, 0, 0, 0, 0, 0, 16'hfffb));
    offer(item_of(KIND_NONE, 4'd0, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                  16'hffff, 16'hffff, 16'hffff));
    offer(item_of(KIND_GRAVITY, 4'd0, 0, 0, 0, 0, 0, 0, 0, 16'd0));
    settle();

    apply_setting(1, 0, RST_FRICTION_SCALE, RST_FRICTION_LIMIT, RST_VELOCITY_DEADBAND,
                  RST_POSTURE_LIMIT, RST_JOINT_COUNT, 0);
    traffic(PHASE_ITEMS, 1'b1);
    apply_setting(1, 1, 16'hffff, 16'h7fff, 0, 16'h7fff, 8, 1);
    traffic(PHASE_ITEMS, 1'b0);
    apply_setting(0, 1, 0, 0, 16'h7fff, 0, 1, 2);
    traffic(PHASE_ITEMS, 1'b0);
    apply_setting(1, 1, 16'd16384, 16'h7fff, 16'd200, 16'h7fff, 15, 3);
    traffic(PHASE_ITEMS, 1'b0);
    apply_setting(1, 1, RST_FRICTION_SCALE, RST_FRICTION_LIMIT, 0, RST_POSTURE_LIMIT, 0, 0);
    traffic(PHASE_ITEMS, 1'b1);
    write_reg(REG_UNUSED, 16'($urandom));
    apply_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom), 1);
    traffic(PHASE_ITEMS, 1'b0);
    apply_setting(1, 1, 16'($urandom), 16'd100, 16'($urandom_range(300)), 16'd50, 8, 2);
    traffic(PHASE_ITEMS, 1'b0);

    $display("Sent %0d load, sample and gravity beats across seven register settings;",
             items_sent);
    $display("checked %0d torque commands under idle, gap, stall and hold patterns.",
             checked);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
